// ----- rtl/core/amf_pkg.sv -----
// ----------------------------------------------------------------------------
// ARX model filter package
// Shared widths, register indexes, defaults and the tap cell control bundle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package amf_pkg;

   localparam int SAMPLE_W   = 16;
   localparam int COEFF_W    = 16;
   localparam int PROD_W     = SAMPLE_W + COEFF_W;
   localparam int FRAC_BITS  = 14;
   localparam int LANE_COUNT = 4;
   localparam int PACKED_W   = LANE_COUNT * COEFF_W;

   localparam int DEF_MAX_A_TAPS = 4;
   localparam int DEF_MAX_B_TAPS = 4;
   localparam int DEF_MAX_DELAY  = 16;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = PACKED_W;
   localparam int TAPS_W      = 3;
   localparam int DELAY_W     = 5;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_A_COEFFS    = 3'd0,
      CSR_B_COEFFS    = 3'd1,
      CSR_NA_USED     = 3'd2,
      CSR_NB_USED     = 3'd3,
      CSR_DELAY_STEPS = 3'd4
   } csr_index_type;

   localparam logic [DELAY_W-1:0] DELAY_RESET = 5'd1;

   typedef struct packed {
      logic advance;   // shift the neighbor's value in
      logic enable;    // tap is within the used count
   } tap_ctrl_type;

endpackage

// ----- rtl/core/arx_model_filter_with_delay_unit.sv -----
// ----------------------------------------------------------------------------
// ARX model filter with transport delay
// A sample transferred in is loaded into the output register and appears on rsp in the cycle after.
// Throughput: one sample per cycle while the sink keeps pace; the bound is the
//   output feedback loop through the A0 tap multiplier and the accumulate tree.
// Reset: synchronous, clears all history cells and the output valid flag and
//   returns the registers to zero coefficients, zero taps and a delay of one.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module arx_model_filter_with_delay_unit
   import amf_pkg::*;
#(
   parameter int MAX_A_TAPS = DEF_MAX_A_TAPS,
   parameter int MAX_B_TAPS = DEF_MAX_B_TAPS,
   parameter int MAX_DELAY  = DEF_MAX_DELAY
)
(
   input  logic                   clock,
   input  logic                   reset,

   // input stream
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [31:0]            req_tdata,   // [15:0] sample_in, [31:16] noise_in

   // result stream
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [15:0]            rsp_tdata,   // [15:0] sample_out

   // register write port
   input  logic                   csr_wen,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam int DLY_IDX_W = (MAX_DELAY > 1) ? $clog2(MAX_DELAY) : 1;
   localparam int ACC_W     = PROD_W + 1 + $clog2(MAX_A_TAPS + MAX_B_TAPS + 2);
   localparam logic signed [ACC_W-1:0] ROUND_BIAS = ACC_W'(1) <<< (FRAC_BITS - 1);
   localparam logic signed [ACC_W-1:0] SAT_HI     = ACC_W'(32767);
   localparam logic signed [ACC_W-1:0] SAT_LO     = -ACC_W'(32768);
   localparam logic [DLY_IDX_W-1:0]    DLY_LAST   = DLY_IDX_W'(MAX_DELAY - 1);

   // ---------------------------------------------------------------------
   // Configuration registers
   // ---------------------------------------------------------------------
   logic [PACKED_W-1:0] a_coeffs_ff;
   logic [PACKED_W-1:0] b_coeffs_ff;
   logic [TAPS_W-1:0]   na_used_ff;
   logic [TAPS_W-1:0]   nb_used_ff;
   logic [DELAY_W-1:0]  delay_steps_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_coeffs_ff    <= '0;
         b_coeffs_ff    <= '0;
         na_used_ff     <= '0;
         nb_used_ff     <= '0;
         delay_steps_ff <= DELAY_RESET;
      end else if (csr_wen) begin
         unique case (csr_index)
            CSR_A_COEFFS:    a_coeffs_ff    <= csr_wdata;
            CSR_B_COEFFS:    b_coeffs_ff    <= csr_wdata;
            CSR_NA_USED:     na_used_ff     <= csr_wdata[TAPS_W-1:0];
            CSR_NB_USED:     nb_used_ff     <= csr_wdata[TAPS_W-1:0];
            CSR_DELAY_STEPS: delay_steps_ff <= csr_wdata[DELAY_W-1:0];
            default: ;  // indexes above the list are ignored
         endcase
      end
   end

   // ---------------------------------------------------------------------
   // Handshake: the output register frees up when it is empty or drained,
   // so a new transfer is taken in every cycle that the sink keeps pace.
   // ---------------------------------------------------------------------
   logic                       rsp_tvalid_ff;
   logic                       rsp_tvalid_in;
   logic [SAMPLE_W-1:0]        rsp_tdata_ff;
   logic                       accept;
   logic signed [SAMPLE_W-1:0] sample_in;
   logic signed [SAMPLE_W-1:0] noise_in;

   assign req_tready    = !rsp_tvalid_ff || rsp_tready;
   assign accept        = req_tvalid && req_tready;
   assign sample_in     = req_tdata[15:0];
   assign noise_in      = req_tdata[31:16];
   assign rsp_tvalid_in = accept || (rsp_tvalid_ff && !rsp_tready);

   // ---------------------------------------------------------------------
   // Transport delay line: a row of cells, newest raw sample in cell 0
   // ---------------------------------------------------------------------
   logic signed [SAMPLE_W-1:0] dly_q [MAX_DELAY];
   logic [DLY_IDX_W-1:0]       dly_sel;
   logic signed [SAMPLE_W-1:0] delayed;

   for (genvar g = 0; g < MAX_DELAY; g++) begin : g_dly
      amf_delay_cell u_cell (
         .clock   (clock),
         .reset   (reset),
         .advance (accept),
         .d       ((g == 0) ? sample_in : dly_q[(g == 0) ? 0 : g - 1]),
         .q       (dly_q[g])
      );
   end

   // clamp the delay into one..MAX_DELAY and tap cell k-1
   always_comb begin
      priority if (delay_steps_ff == '0) begin
         dly_sel = '0;
      end else if (32'(delay_steps_ff) > MAX_DELAY) begin
         dly_sel = DLY_LAST;
      end else begin
         dly_sel = DLY_IDX_W'(delay_steps_ff - DELAY_W'(1));
      end
   end

   // read before the shift: the stored raw samples feed the tap
   assign delayed = dly_q[dly_sel];

   // ---------------------------------------------------------------------
   // Input history chain: each cell multiplies the value it is loading,
   // which is the history after this transfer's shift.
   // ---------------------------------------------------------------------
   logic signed [SAMPLE_W-1:0] b_q    [MAX_B_TAPS];
   logic signed [PROD_W-1:0]   b_prod [MAX_B_TAPS];

   for (genvar g = 0; g < MAX_B_TAPS; g++) begin : g_b
      logic signed [COEFF_W-1:0] coeff;
      tap_ctrl_type              ctrl;

      if (g < LANE_COUNT) begin : g_lane
         assign coeff = b_coeffs_ff[COEFF_W*g +: COEFF_W];
      end else begin : g_zero
         assign coeff = '0;
      end

      assign ctrl.advance = accept;
      assign ctrl.enable  = 32'(nb_used_ff) > g;

      amf_tap_cell #(.USE_INCOMING(1'b1)) u_cell (
         .clock (clock),
         .reset (reset),
         .ctrl  (ctrl),
         .coeff (coeff),
         .d     ((g == 0) ? delayed : b_q[(g == 0) ? 0 : g - 1]),
         .q     (b_q[g]),
         .prod  (b_prod[g])
      );
   end

   // ---------------------------------------------------------------------
   // Output history chain: each cell multiplies its stored past output;
   // cell 0 loads the new result.
   // ---------------------------------------------------------------------
   logic signed [SAMPLE_W-1:0] a_q    [MAX_A_TAPS];
   logic signed [PROD_W-1:0]   a_prod [MAX_A_TAPS];
   logic signed [SAMPLE_W-1:0] y_new;

   for (genvar g = 0; g < MAX_A_TAPS; g++) begin : g_a
      logic signed [COEFF_W-1:0] coeff;
      tap_ctrl_type              ctrl;

      if (g < LANE_COUNT) begin : g_lane
         assign coeff = a_coeffs_ff[COEFF_W*g +: COEFF_W];
      end else begin : g_zero
         assign coeff = '0;
      end

      assign ctrl.advance = accept;
      assign ctrl.enable  = 32'(na_used_ff) > g;

      amf_tap_cell #(.USE_INCOMING(1'b0)) u_cell (
         .clock (clock),
         .reset (reset),
         .ctrl  (ctrl),
         .coeff (coeff),
         .d     ((g == 0) ? y_new : a_q[(g == 0) ? 0 : g - 1]),
         .q     (a_q[g]),
         .prod  (a_prod[g])
      );
   end

   // ---------------------------------------------------------------------
   // Accumulate, round half up, floor-shift, saturate
   // ---------------------------------------------------------------------
   logic signed [ACC_W-1:0] acc;
   logic signed [ACC_W-1:0] shifted;

   always_comb begin
      acc = (ACC_W'(noise_in) <<< FRAC_BITS) + ROUND_BIAS;
      for (int i = 0; i < MAX_B_TAPS; i++) begin
         acc = acc + ACC_W'(b_prod[i]);
      end
      for (int i = 0; i < MAX_A_TAPS; i++) begin
         acc = acc - ACC_W'(a_prod[i]);
      end
      shifted = acc >>> FRAC_BITS;
      priority if (shifted > SAT_HI) begin
         y_new = SAMPLE_W'(SAT_HI);
      end else if (shifted < SAT_LO) begin
         y_new = SAMPLE_W'(SAT_LO);
      end else begin
         y_new = shifted[SAMPLE_W-1:0];
      end
   end

   // ---------------------------------------------------------------------
   // Output register: hold while stalled, load on every accepted transfer
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else begin
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_tdata_ff <= y_new;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

endmodule

// ----- rtl/core/amf_delay_cell.sv -----
// ----------------------------------------------------------------------------
// ARX model filter delay cell
// One stage of the transport delay line; loads its neighbor on advance.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module amf_delay_cell
   import amf_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       advance,
   input  logic signed [SAMPLE_W-1:0] d,
   output logic signed [SAMPLE_W-1:0] q
);

   logic signed [SAMPLE_W-1:0] value_ff;
   logic signed [SAMPLE_W-1:0] value_in;

   assign value_in = advance ? d : value_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         value_ff <= '0;
      end else begin
         value_ff <= value_in;
      end
   end

   assign q = value_ff;

endmodule

// ----- rtl/core/amf_tap_cell.sv -----
// ----------------------------------------------------------------------------
// ARX model filter tap cell
// One history entry with its coefficient product; shifts on advance.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module amf_tap_cell
   import amf_pkg::*;
#(
   // 1: multiply the value being loaded, 0: multiply the stored value
   parameter bit USE_INCOMING = 1'b0
)
(
   input  logic                       clock,
   input  logic                       reset,
   input  tap_ctrl_type               ctrl,
   input  logic signed [COEFF_W-1:0]  coeff,
   input  logic signed [SAMPLE_W-1:0] d,
   output logic signed [SAMPLE_W-1:0] q,
   output logic signed [PROD_W-1:0]   prod
);

   logic signed [SAMPLE_W-1:0] value_ff;
   logic signed [SAMPLE_W-1:0] value_in;
   logic signed [SAMPLE_W-1:0] operand;

   assign value_in = ctrl.advance ? d : value_ff;
   assign operand  = USE_INCOMING ? d : value_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         value_ff <= '0;
      end else begin
         value_ff <= value_in;
      end
   end

   // drop taps beyond the used count
   assign prod = ctrl.enable ? (PROD_W'(coeff) * PROD_W'(operand)) : '0;
   assign q    = value_ff;

endmodule

// ----- sim/arx_model_filter_with_delay_unit_test.sv -----
// ----------------------------------------------------------------------------
// ARX model filter with transport delay: self-checking testbench
// Drives samples and noise through the stream port and programs the tap
// registers between phases. A scoreboard keeps its own copy of the delay
// line and histories and checks every output in arrival order. Flow control
// cycles through free flow, sender gaps, receiver stalls and both at once.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

class arx_output_checker;

   logic [amf_pkg::PACKED_W-1:0]           a_packed;
   logic [amf_pkg::PACKED_W-1:0]           b_packed;
   logic [amf_pkg::TAPS_W-1:0]             na_reg;
   logic [amf_pkg::TAPS_W-1:0]             nb_reg;
   logic [amf_pkg::DELAY_W-1:0]            delay_reg;
   logic signed [amf_pkg::SAMPLE_W-1:0]    raw_line [amf_pkg::DEF_MAX_DELAY];
   logic signed [amf_pkg::SAMPLE_W-1:0]    u_hist [amf_pkg::DEF_MAX_B_TAPS];
   logic signed [amf_pkg::SAMPLE_W-1:0]    y_hist [amf_pkg::DEF_MAX_A_TAPS];
   logic [amf_pkg::SAMPLE_W-1:0]           expected_y [$];
   int                                     samples;
   int                                     outputs;
   int                                     mismatches;

   function new();
      a_packed   = '0;
      b_packed   = '0;
      na_reg     = '0;
      nb_reg     = '0;
      delay_reg  = amf_pkg::DELAY_RESET;
      foreach (raw_line[i]) raw_line[i] = '0;
      foreach (u_hist[i]) u_hist[i] = '0;
      foreach (y_hist[i]) y_hist[i] = '0;
      samples    = 0;
      outputs    = 0;
      mismatches = 0;
   endfunction

   function void write_reg(logic [amf_pkg::CSR_INDEX_W-1:0] idx,
                           logic [amf_pkg::CSR_DATA_W-1:0] value);
      case (idx)
         amf_pkg::CSR_A_COEFFS:    a_packed = value;
         amf_pkg::CSR_B_COEFFS:    b_packed = value;
         amf_pkg::CSR_NA_USED:     na_reg = value[amf_pkg::TAPS_W-1:0];
         amf_pkg::CSR_NB_USED:     nb_reg = value[amf_pkg::TAPS_W-1:0];
         amf_pkg::CSR_DELAY_STEPS: delay_reg = value[amf_pkg::DELAY_W-1:0];
         default: ;
      endcase
   endfunction

   // Advance the filter by one sample and queue the output it must produce.
   function void note_sample(logic [15:0] u, logic [15:0] noise);
      int                                  k;
      int                                  na;
      int                                  nb;
      longint                              acc;
      logic signed [amf_pkg::SAMPLE_W-1:0] delayed;
      k  = (delay_reg == 0) ? 1 :
           (delay_reg > amf_pkg::DEF_MAX_DELAY) ? amf_pkg::DEF_MAX_DELAY : int'(delay_reg);
      na = (na_reg > amf_pkg::DEF_MAX_A_TAPS) ? amf_pkg::DEF_MAX_A_TAPS : int'(na_reg);
      nb = (nb_reg > amf_pkg::DEF_MAX_B_TAPS) ? amf_pkg::DEF_MAX_B_TAPS : int'(nb_reg);
      samples++;

      delayed = raw_line[k-1];
      for (int i = amf_pkg::DEF_MAX_DELAY - 1; i > 0; i--) raw_line[i] = raw_line[i-1];
      raw_line[0] = u;
      for (int i = amf_pkg::DEF_MAX_B_TAPS - 1; i > 0; i--) u_hist[i] = u_hist[i-1];
      u_hist[0] = delayed;

      acc = longint'($signed(noise)) * (longint'(1) <<< amf_pkg::FRAC_BITS);
      for (int i = 0; i < nb; i++)
         acc += longint'($signed(b_packed[amf_pkg::COEFF_W*i +: amf_pkg::COEFF_W]))
                * longint'(u_hist[i]);
      for (int i = 0; i < na; i++)
         acc -= longint'($signed(a_packed[amf_pkg::COEFF_W*i +: amf_pkg::COEFF_W]))
                * longint'(y_hist[i]);

      // round half up, floor to integer, then clip to 16 bits
      acc = (acc + (longint'(1) <<< (amf_pkg::FRAC_BITS - 1))) >>> amf_pkg::FRAC_BITS;
      if (acc > 32767) acc = 32767;
      if (acc < -32768) acc = -32768;

      for (int i = amf_pkg::DEF_MAX_A_TAPS - 1; i > 0; i--) y_hist[i] = y_hist[i-1];
      y_hist[0] = acc[15:0];
      expected_y.insert(expected_y.size(), acc[15:0]);
   endfunction

   function void check_output(logic [15:0] y);
      logic [15:0] want;
      outputs++;
      if (expected_y.size() == 0) begin
         $error("sample_out transfer with nothing pending: expected none, actual %0d",
                $signed(y));
         mismatches++;
         return;
      end
      want = expected_y[0];
      expected_y.delete(0);
      if (y !== want) begin
         $error("sample_out mismatch: expected %0d, actual %0d", $signed(want), $signed(y));
         mismatches++;
      end
   endfunction

endclass

module arx_model_filter_with_delay_unit_test;

   import amf_pkg::*;

   localparam int SEGMENTS          = 16;
   localparam int SEGMENT_SAMPLES   = 90;
   localparam int SETTLE_CYCLES     = 4;   // margin after the last pending output has arrived
   localparam int STABLE_MAG        = 'h0F00;
   localparam int FIRST_UNUSED_CSR  = int'(CSR_DELAY_STEPS) + 1;
   localparam int LAST_CSR          = (1 << CSR_INDEX_W) - 1;

   // flow-control mixes: free, sender gaps, receiver stalls, both
   localparam int SEND_IDLE_PCT  [4] = '{0, 80, 0, 23};
   localparam int RECV_STALL_PCT [4] = '{0, 0, 80, 23};
   localparam logic [15:0] EDGE_LANES [4] = '{16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF};

   logic                   clock;
   logic                   reset       = 1'b1;
   logic                   req_tvalid  = 1'b0;
   logic                   req_tready;
   logic [31:0]            req_tdata   = '0;   // [15:0] sample_in, [31:16] noise_in
   logic                   rsp_tvalid;
   logic                   rsp_tready  = 1'b0;
   logic [15:0]            rsp_tdata;          // [15:0] sample_out
   logic                   csr_wen     = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index   = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata   = '0;

   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int settings_run   = 0;

   arx_output_checker sb = new();

   arx_model_filter_with_delay_unit i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wen    (csr_wen),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Hard stop in case the block hangs on a handshake.
   initial begin
      #5ms;
      $display("Simulation FAILED");
      $finish;
   end

   // Randomly stall the result side; one update per edge.
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // Monitor both streams. Note the input first so a same-edge result still
   // pairs with the oldest pending sample.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) sb.note_sample(req_tdata[15:0], req_tdata[31:16]);
         if (rsp_tvalid && rsp_tready) sb.check_output(rsp_tdata);
      end
   end

   task automatic set_flow(int mode);
      send_idle_pct  = SEND_IDLE_PCT[mode];
      recv_stall_pct = RECV_STALL_PCT[mode];
   endtask

   // Offer one sample, with random idle cycles ahead of it, and hold it until
   // the transfer. Valid stays high so back-to-back samples need no gap.
   task automatic send_sample(logic [15:0] u, logic [15:0] noise);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {noise, u};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   // Drop valid and hold off until every pending output has arrived.
   task automatic wait_for_outputs();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (sb.expected_y.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Leave the enable high; program_regs lowers it after the last write.
   task automatic write_csr(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] value);
      csr_wen   <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      sb.write_reg(idx, value);
      @(posedge clock);
   endtask

   task automatic program_regs(logic [CSR_DATA_W-1:0] a, logic [CSR_DATA_W-1:0] b,
                               logic [CSR_DATA_W-1:0] na, logic [CSR_DATA_W-1:0] nb,
                               logic [CSR_DATA_W-1:0] delay);
      write_csr(CSR_A_COEFFS, a);
      write_csr(CSR_B_COEFFS, b);
      write_csr(CSR_NA_USED, na);
      write_csr(CSR_NB_USED, nb);
      write_csr(CSR_DELAY_STEPS, delay);
      csr_wen <= 1'b0;
      settings_run++;
   endtask

   // Lane styles: 0 keeps the feedback stable, 1 is fully random, else edges.
   function automatic logic [PACKED_W-1:0] random_lanes(int style);
      logic [PACKED_W-1:0] v;
      for (int i = 0; i < LANE_COUNT; i++) begin
         case (style)
            0:       v[COEFF_W*i +: COEFF_W] =
                        COEFF_W'($urandom_range(0, 2 * STABLE_MAG) - STABLE_MAG);
            1:       v[COEFF_W*i +: COEFF_W] = COEFF_W'($urandom);
            default: v[COEFF_W*i +: COEFF_W] = EDGE_LANES[$urandom_range(3)];
         endcase
      end
      return v;
   endfunction

   task automatic send_random_sample();
      logic [15:0] u;
      logic [15:0] noise;
      case ($urandom_range(3))
         0:       u = SAMPLE_W'($urandom_range(0, 512) - 256);
         1:       u = EDGE_LANES[$urandom_range(3)];
         default: u = SAMPLE_W'($urandom);
      endcase
      case ($urandom_range(3))
         0:       noise = '0;
         1:       noise = SAMPLE_W'($urandom_range(0, 128) - 64);
         default: noise = SAMPLE_W'($urandom);
      endcase
      send_sample(u, noise);
   endtask

   initial begin
      logic [CSR_DATA_W-1:0] na_val;
      logic [CSR_DATA_W-1:0] nb_val;
      logic [CSR_DATA_W-1:0] delay_val;

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      set_flow(0);

      // Reset settings: no taps, so the output is the noise alone.
      send_sample(16'h7FFF, 16'h7FFF);
      send_sample(16'h8000, 16'h8000);
      send_sample(16'h0000, 16'h0000);
      send_sample(16'hFFFF, 16'h0001);
      send_sample(16'h1234, 16'hFFFF);
      wait_for_outputs();

      // Unused indexes must not disturb anything.
      for (int idx = FIRST_UNUSED_CSR; idx <= LAST_CSR; idx++)
         write_csr(CSR_INDEX_W'(idx), '1);

      // Extreme lanes, oversized tap counts and a zero delay; upper bits of
      // the narrow registers are junk and must be masked.
      program_regs({16'hC000, 16'h4000, 16'h7FFF, 16'h8000},
                   {16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF},
                   64'hFFFF_FFFF_FFFF_FFF7, 64'hFFFF_FFFF_FFFF_FFF7,
                   64'hFFFF_FFFF_FFFF_FFE0);
      set_flow(3);
      send_sample(16'h7FFF, 16'h7FFF);
      send_sample(16'h7FFF, 16'h7FFF);
      send_sample(16'h8000, 16'h8000);
      send_sample(16'h8000, 16'h8000);
      send_sample(16'h0000, 16'h0000);
      send_sample(16'hFFFF, 16'h0001);
      wait_for_outputs();

      // Delay beyond the line length clamps to the deepest tap.
      program_regs({16'hC000, 16'h4000, 16'h7FFF, 16'h8000},
                   {16'h0000, 16'h0000, 16'h0000, 16'h4000}, 0, 1, 31);
      send_sample(16'h0001, 16'h0000);
      send_sample(16'hFFFF, 16'h0000);
      send_sample(16'h7FFF, 16'h8000);
      send_sample(16'h8000, 16'h7FFF);
      wait_for_outputs();

      // Shorten the delay with data in flight; a half gain exposes rounding.
      program_regs({16'hC000, 16'h4000, 16'h7FFF, 16'h8000},
                   {16'h0000, 16'h0000, 16'h0000, 16'h2000}, 0, 1, 5);
      send_sample(16'h0001, 16'h0000);
      send_sample(16'hFFFF, 16'h0000);
      send_sample(16'h0003, 16'h0000);
      send_sample(16'hFFFD, 16'h0000);
      wait_for_outputs();

      // Full input taps, one feedback tap, exact maximum delay.
      program_regs({16'h0000, 16'h0000, 16'h0000, 16'h2000},
                   {16'hF800, 16'h0800, 16'hF000, 16'h1000}, 1, 4, 16);
      send_sample(16'h1234, 16'h0000);
      send_sample(16'hEDCC, 16'h0010);
      send_sample(16'h7FFF, 16'hFFF0);
      send_sample(16'h8000, 16'h0000);
      wait_for_outputs();

      // Random settings, rotating through the flow-control mixes.
      for (int seg = 0; seg < SEGMENTS; seg++) begin
         na_val    = {$urandom, $urandom};
         nb_val    = {$urandom, $urandom};
         delay_val = {$urandom, $urandom};
         na_val[TAPS_W-1:0] = TAPS_W'($urandom_range(0, 7));
         nb_val[TAPS_W-1:0] = TAPS_W'($urandom_range(0, 7));
         case (seg % 5)
            0:       delay_val[DELAY_W-1:0] = DELAY_W'(0);
            1:       delay_val[DELAY_W-1:0] = DELAY_W'(1);
            2:       delay_val[DELAY_W-1:0] = DELAY_W'(DEF_MAX_DELAY);
            3:       delay_val[DELAY_W-1:0] =
                        DELAY_W'($urandom_range(DEF_MAX_DELAY + 1, 31));
            default: delay_val[DELAY_W-1:0] =
                        DELAY_W'($urandom_range(2, DEF_MAX_DELAY - 1));
         endcase
         program_regs(random_lanes((seg % 4 == 1) ? 1 : (seg % 8 == 5) ? 2 : 0),
                      random_lanes($urandom_range(2)), na_val, nb_val, delay_val);
         set_flow(seg % 4);
         repeat (SEGMENT_SAMPLES) send_random_sample();
         wait_for_outputs();
      end

      $display("Ran %0d samples and checked %0d outputs over %0d register settings,",
               sb.samples, sb.outputs, settings_run);
      $display("under free flow, sender gaps, receiver stalls and both; %0d mismatches.",
               sb.mismatches);
      if (sb.mismatches == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
